FILE: design/dcht_pkg.sv
// shared sizes and types for the duplicate command history table
// used by dcht_cell and duplicate_command_history_table; no dependencies
`default_nettype none

package dcht_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int KEY_BYTES     = 8;
  localparam int SESSION_BYTES = 8;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int SES_W = 8 * SESSION_BYTES;
  localparam int AMT_W = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_LOOKUP          = 2'd0;
  localparam logic [1:0] OP_REGISTER        = 2'd1;
  localparam logic [1:0] OP_REGISTER_RESULT = 2'd2;
  localparam logic [1:0] OP_CLEAR           = 2'd3;

  // search token walking down the row of cells
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             done;
    logic [AMT_W-1:0] amount;
    logic [SES_W-1:0] session;
    logic [KEY_W-1:0] key;
  } token_t;

  // write broadcast to every cell
  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic             done;
    logic [AMT_W-1:0] amount;
    logic [SES_W-1:0] session;
  } wr_t;

endpackage

`default_nettype wire

FILE: design/duplicate_command_history_table.sv
// top level of the duplicate command history table: control, pointer, count
// and the row of dcht_cell entries; depends on dcht_pkg and dcht_cell
// a search passes the token through the cell registers of the row in turn, latches
//   its outcome, then loads the result register; clear or a zero key skips the row
// in_stall holds off a new command until the last result is loaded; the search token
//   walking the cell row sets how long a search takes, and result stalls add to it
// reset: synchronous active-low rst_n empties every slot and zeroes pointer/count
`default_nettype none

module duplicate_command_history_table (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_operation,
  input  wire  [63:0] in_cmd_key,
  input  wire  [31:0] in_amount_in,
  input  wire  [63:0] in_session_in,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_found,
  output logic        out_is_done,
  output logic [31:0] out_amount_out,
  output logic [63:0] out_session_out,
  output logic [5:0]  out_entry_count
);
  import dcht_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             inject_r;

  // latched command
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [AMT_W-1:0] amount_r;
  logic [SES_W-1:0] session_r;

  // latched search outcome
  logic             res_hit_r;
  logic [IDX_W-1:0] res_idx_r;
  logic             res_done_r;
  logic [AMT_W-1:0] res_amount_r;
  logic [SES_W-1:0] res_session_r;

  logic [IDX_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic             out_valid_r;
  logic             out_found_r;
  logic             out_is_done_r;
  logic [AMT_W-1:0] out_amount_r;
  logic [SES_W-1:0] out_session_r;
  logic [5:0]       out_count_r;

  logic             in_xfer;
  logic             load_ok;
  logic             finish;
  logic [KEY_W-1:0] in_key;
  wr_t              wr;
  token_t           tok_head;
  token_t           chain [TABLE_DEPTH+1];
  token_t           tail;

  assign in_key   = in_cmd_key[KEY_W-1:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // result slot free, or being drained this cycle
  assign load_ok = !out_valid_r || !out_stall;
  assign finish  = (state_r == S_DONE) && load_ok;

  // token enters the first cell in the cycle after the transfer
  always_comb begin
    tok_head       = '0;
    tok_head.valid = inject_r;
    tok_head.key   = key_r;
  end

  assign chain[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      dcht_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(gi)),
        .wr       (wr),
        .tok_in   (chain[gi]),
        .tok_out  (chain[gi+1])
      );
    end
  endgenerate

  assign tail = chain[TABLE_DEPTH];

  // control sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // clear and a zero key need no search
          if (in_operation == OP_CLEAR || in_key == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (tail.valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table update: matched slot, otherwise the slot at the write pointer
  always_comb begin
    wr         = '0;
    wr.key     = key_r;
    wr.idx     = res_hit_r ? res_idx_r : wp_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    if (op_r == OP_REGISTER_RESULT) begin
      wr.done    = 1'b1;
      wr.amount  = amount_r;
      wr.session = session_r;
    end
    if (op_r == OP_CLEAR) begin
      wr.clr  = finish;
      wp_nxt  = '0;
      cnt_nxt = '0;
    end else if (op_r != OP_LOOKUP && key_r != '0) begin
      wr.we = finish;
      if (!res_hit_r) begin
        wp_nxt = (wp_r == IDX_W'(TABLE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (cnt_r != CNT_W'(TABLE_DEPTH)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inject_r <= 1'b0;
      wp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      inject_r <= in_xfer && in_operation != OP_CLEAR && in_key != '0;
      if (finish) begin
        wp_r  <= wp_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // command and search outcome capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_operation;
      key_r     <= in_key;
      amount_r  <= in_amount_in;
      session_r <= in_session_in[SES_W-1:0];
      res_hit_r <= 1'b0;
    end else if (state_r == S_SEARCH && tail.valid) begin
      res_hit_r     <= tail.hit;
      res_idx_r     <= tail.idx;
      res_done_r    <= tail.done;
      res_amount_r  <= tail.amount;
      res_session_r <= tail.session;
    end
  end

  // result register, found fields only meaningful for a lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_found_r   <= (op_r == OP_LOOKUP) && res_hit_r;
      out_is_done_r <= (op_r == OP_LOOKUP) && res_hit_r && res_done_r;
      out_amount_r  <= ((op_r == OP_LOOKUP) && res_hit_r && res_done_r) ? res_amount_r : '0;
      out_session_r <= ((op_r == OP_LOOKUP) && res_hit_r && res_done_r) ? res_session_r : '0;
      out_count_r   <= 6'(cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_is_done     = out_is_done_r;
  assign out_amount_out  = out_amount_r;
  assign out_session_out = 64'(out_session_r);
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

FILE: design/dcht_cell.sv
// one table entry plus one stage of the search token chain
// depends on dcht_pkg
`default_nettype none

module dcht_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [dcht_pkg::IDX_W-1:0]   cell_idx,
  input  wire  dcht_pkg::wr_t          wr,
  input  wire  dcht_pkg::token_t       tok_in,
  output dcht_pkg::token_t             tok_out
);
  import dcht_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic             done_r;
  logic [AMT_W-1:0] amount_r;
  logic [SES_W-1:0] session_r;
  token_t           tok_r;
  token_t           tok_nxt;

  // entry storage, a zero key marks the slot empty
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr) begin
      key_r  <= '0;
      done_r <= 1'b0;
    end else if (wr.we && wr.idx == cell_idx) begin
      key_r     <= wr.key;
      done_r    <= wr.done;
      amount_r  <= wr.amount;
      session_r <= wr.session;
    end
  end

  // first matching cell stamps its entry into the token
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.hit && key_r == tok_in.key) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.idx     = cell_idx;
      tok_nxt.done    = done_r;
      tok_nxt.amount  = amount_r;
      tok_nxt.session = session_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire
